// ===== src/arfp_pkg.sv =====
// Shared types and constants for the ASCII response frame parser.
`default_nettype none
package arfp_pkg;

  // Input transaction modes
  typedef enum logic [1:0] {
    MODE_QUERY = 2'd0,
    MODE_BYTE  = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_LINK  = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MALFORM  = 3'd1,
    ST_COUNT    = 3'd2,
    ST_ID       = 3'd3,
    ST_CHECKSUM = 3'd4,
    ST_NODATA   = 3'd5,
    ST_DROP     = 3'd6
  } status_t;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_UNIT_ID   = 2'd0;
  localparam logic [1:0] REG_VARIANT   = 2'd1;
  localparam logic [1:0] REG_EXP_COUNT = 2'd2;
  localparam int ADDR_W = 4;

  localparam logic [7:0] UNIT_ID_RST   = 8'd49;
  localparam logic [6:0] EXP_COUNT_RST = 7'd1;

  // Frame layout
  localparam logic [7:0] CR_CHAR        = 8'h0D;
  localparam logic [7:0] TOK_ID         = 8'd2;
  localparam logic [7:0] TOK_MIN        = 8'd3;
  localparam logic [7:0] TOK_VALUE_BASE = 8'd4;
  localparam logic [8:0] TOK_EXTRA      = 9'd5;
  localparam logic [7:0] TOK_MAX        = 8'd255;

  // Characters used by the decimal decoder
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  localparam int CNT_W      = 7;  // holds a value count up to 64
  localparam int CMDQ_DEPTH = 2;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic               has_value;
    logic [5:0]         value_index;
    logic signed [15:0] reading;
    logic               last;
  } result_t;

  // Command from front to back: one status result or a burst of readings
  typedef struct packed {
    status_t          status;
    logic             burst;
    logic [CNT_W-1:0] count;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_READ = 2'd1,
    B_SEND = 2'd2
  } back_state_t;

endpackage
`default_nettype wire

// ===== src/arfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module arfp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== src/arfp_cmd_fifo.sv =====
// Short command queue between the parsing front and the emitting back.
`default_nettype none
module arfp_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire arfp_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output arfp_pkg::cmd_t      head,
  output logic                empty,
  output logic                full
);

  localparam int PW = (arfp_pkg::CMDQ_DEPTH > 1) ? $clog2(arfp_pkg::CMDQ_DEPTH) : 1;
  localparam int CW = $clog2(arfp_pkg::CMDQ_DEPTH + 1);

  arfp_pkg::cmd_t entry_r [arfp_pkg::CMDQ_DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Pointer wrap helper
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(arfp_pkg::CMDQ_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CW'(arfp_pkg::CMDQ_DEPTH));
  assign head  = entry_r[rptr_r];

  // Pointer and occupancy update
  always_comb begin
    wptr_nxt = push ? ptr_inc(wptr_r) : wptr_r;
    rptr_nxt = pop ? ptr_inc(rptr_r) : rptr_r;
    cnt_nxt  = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== src/arfp_front.sv =====
// Front end: takes input transactions, tracks frame state, judges replies.
`default_nettype none
module arfp_front #(
  parameter int MAX_VALUES    = 64,
  parameter int TIMEOUT_LIMIT = 5,
  parameter int IW            = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire arfp_pkg::item_t in_data,
  input  wire logic [7:0]      unit_id,
  input  wire logic            plc_variant,
  input  wire logic [6:0]      expected_count,
  input  wire logic            q_full,
  output logic                 q_push,
  output arfp_pkg::cmd_t       q_cmd,
  input  wire logic            burst_done,
  output logic                 st_we,
  output logic [IW-1:0]        st_waddr,
  output logic [15:0]          st_wdata
);

  logic [7:0]  tok_cnt_r, tok_cnt_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [31:0] sbt_r, sbt_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt;
  logic        done_r, done_nxt;
  logic        begun_r, begun_nxt;
  logic        in_tok_r, in_tok_nxt;
  logic        id_ok_r, id_ok_nxt;
  logic [1:0]  cr_run_r, cr_run_nxt;
  logic [2:0]  tmo_r, tmo_nxt;
  logic        burst_pend_r, burst_pend_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        is_digit;
  logic [31:0] tok_value;
  logic [7:0]  val_idx;
  logic [3:0]  tmo_inc;
  logic [1:0]  cr_need;
  logic [1:0]  cr_run_new;
  // Judge status, decided from the frame state as it stands
  arfp_pkg::status_t status_sel;

  assign accept    = in_valid && in_ready;
  assign b         = in_data.rx_byte;
  assign is_digit  = (b >= arfp_pkg::CH_ZERO) && (b <= arfp_pkg::CH_NINE);
  assign tok_value = neg_r ? (32'd0 - acc_r) : acc_r;
  assign val_idx   = tok_cnt_r - arfp_pkg::TOK_VALUE_BASE;
  assign tmo_inc   = {1'b0, tmo_r} + 4'd1;
  assign cr_need   = plc_variant ? 2'd3 : 2'd2;
  assign cr_run_new = (cr_run_r == 2'd3) ? 2'd3 : (cr_run_r + 2'd1);

  // All input waits while the queue is full; bytes also wait while a reading burst needs the value store
  assign in_ready = !q_full &&
                    !(burst_pend_r && (in_data.mode == arfp_pkg::MODE_BYTE));

  // Reply checks in priority order
  always_comb begin
    priority if (tok_cnt_r < arfp_pkg::TOK_MIN) begin
      status_sel = arfp_pkg::ST_MALFORM;
    end else if ((expected_count > 7'(MAX_VALUES)) ||
                 ({1'b0, tok_cnt_r} != ({2'b0, expected_count} + arfp_pkg::TOK_EXTRA))) begin
      status_sel = arfp_pkg::ST_COUNT;
    end else if (!id_ok_r) begin
      status_sel = arfp_pkg::ST_ID;
    end else if (sbt_r != tok_value) begin
      status_sel = arfp_pkg::ST_CHECKSUM;
    end else begin
      status_sel = arfp_pkg::ST_OK;
    end
  end

  // Next-state logic for frame, timeout and burst tracking
  always_comb begin
    logic [31:0] acc_w;
    logic        neg_w;
    logic        done_w;
    logic        begun_w;

    tok_cnt_nxt    = tok_cnt_r;
    sum_nxt        = sum_r;
    sbt_nxt        = sbt_r;
    acc_nxt        = acc_r;
    neg_nxt        = neg_r;
    done_nxt       = done_r;
    begun_nxt      = begun_r;
    in_tok_nxt     = in_tok_r;
    id_ok_nxt      = id_ok_r;
    cr_run_nxt     = cr_run_r;
    tmo_nxt        = tmo_r;
    burst_pend_nxt = burst_pend_r && !burst_done;
    q_push         = 1'b0;
    q_cmd          = '{status: arfp_pkg::ST_OK, burst: 1'b0, count: '0};
    st_we          = 1'b0;
    st_waddr       = val_idx[IW-1:0];
    st_wdata       = tok_value[15:0];
    acc_w          = acc_r;
    neg_w          = neg_r;
    done_w         = done_r;
    begun_w        = begun_r;

    if (accept) begin
      unique case (in_data.mode)
        arfp_pkg::MODE_QUERY: begin
          tok_cnt_nxt = '0;
          sum_nxt     = '0;
          sbt_nxt     = '0;
          acc_nxt     = '0;
          neg_nxt     = 1'b0;
          done_nxt    = 1'b0;
          begun_nxt   = 1'b0;
          in_tok_nxt  = 1'b0;
          id_ok_nxt   = 1'b0;
          cr_run_nxt  = '0;
        end
        arfp_pkg::MODE_TICK: begin
          q_push = 1'b1;
          if (tmo_inc > 4'(TIMEOUT_LIMIT)) begin
            tmo_nxt      = '0;
            q_cmd.status = arfp_pkg::ST_DROP;
          end else begin
            tmo_nxt      = tmo_inc[2:0];
            q_cmd.status = arfp_pkg::ST_NODATA;
          end
        end
        arfp_pkg::MODE_LINK: begin
          q_push       = 1'b1;
          q_cmd.status = arfp_pkg::ST_NODATA;
        end
        arfp_pkg::MODE_BYTE: begin
          tmo_nxt = '0;
          sum_nxt = sum_r + {24'd0, b};
          if (b == arfp_pkg::CR_CHAR) begin
            // Token end: store a value token, count it
            if (in_tok_r) begin
              if ((tok_cnt_r >= arfp_pkg::TOK_VALUE_BASE) && (val_idx < 8'(MAX_VALUES))) begin
                st_we = 1'b1;
              end
              if (tok_cnt_r != arfp_pkg::TOK_MAX) begin
                tok_cnt_nxt = tok_cnt_r + 8'd1;
              end
              in_tok_nxt = 1'b0;
            end
            cr_run_nxt = cr_run_new;
            // Reply end: judge and start a new frame
            if (cr_run_new >= cr_need) begin
              q_push       = 1'b1;
              q_cmd.status = status_sel;
              if ((status_sel == arfp_pkg::ST_OK) && (expected_count != 7'd0)) begin
                q_cmd.burst    = 1'b1;
                q_cmd.count    = expected_count;
                burst_pend_nxt = 1'b1;
              end
              tok_cnt_nxt = '0;
              sum_nxt     = '0;
              sbt_nxt     = '0;
              acc_nxt     = '0;
              neg_nxt     = 1'b0;
              done_nxt    = 1'b0;
              begun_nxt   = 1'b0;
              in_tok_nxt  = 1'b0;
              id_ok_nxt   = 1'b0;
              cr_run_nxt  = '0;
            end
          end else begin
            cr_run_nxt = '0;
            // Token start
            if (!in_tok_r) begin
              in_tok_nxt = 1'b1;
              sbt_nxt    = sum_r;
              acc_w      = '0;
              neg_w      = 1'b0;
              done_w     = 1'b0;
              begun_w    = 1'b0;
              if (tok_cnt_r == arfp_pkg::TOK_ID) begin
                id_ok_nxt = (b == unit_id);
              end
            end
            // Decimal decoder step
            if (!done_w) begin
              if (!begun_w) begin
                if ((b == arfp_pkg::CH_SPACE) ||
                    ((b >= arfp_pkg::CH_TAB) && (b <= arfp_pkg::CH_FF))) begin
                  // leading white space skipped
                end else if ((b == arfp_pkg::CH_PLUS) || (b == arfp_pkg::CH_MINUS)) begin
                  begun_w = 1'b1;
                  neg_w   = (b == arfp_pkg::CH_MINUS);
                end else if (is_digit) begin
                  begun_w = 1'b1;
                  acc_w   = {24'd0, b - arfp_pkg::CH_ZERO};
                end else begin
                  done_w = 1'b1;
                end
              end else if (is_digit) begin
                acc_w = (acc_w << 3) + (acc_w << 1) + {24'd0, b - arfp_pkg::CH_ZERO};
              end else begin
                done_w = 1'b1;
              end
            end
            acc_nxt   = acc_w;
            neg_nxt   = neg_w;
            done_nxt  = done_w;
            begun_nxt = begun_w;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_cnt_r    <= '0;
      sum_r        <= '0;
      sbt_r        <= '0;
      acc_r        <= '0;
      neg_r        <= 1'b0;
      done_r       <= 1'b0;
      begun_r      <= 1'b0;
      in_tok_r     <= 1'b0;
      id_ok_r      <= 1'b0;
      cr_run_r     <= '0;
      tmo_r        <= '0;
      burst_pend_r <= 1'b0;
    end else begin
      tok_cnt_r    <= tok_cnt_nxt;
      sum_r        <= sum_nxt;
      sbt_r        <= sbt_nxt;
      acc_r        <= acc_nxt;
      neg_r        <= neg_nxt;
      done_r       <= done_nxt;
      begun_r      <= begun_nxt;
      in_tok_r     <= in_tok_nxt;
      id_ok_r      <= id_ok_nxt;
      cr_run_r     <= cr_run_nxt;
      tmo_r        <= tmo_nxt;
      burst_pend_r <= burst_pend_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/arfp_back.sv =====
// Back end: turns queued commands into result transactions.
`default_nettype none
module arfp_back #(
  parameter int MAX_VALUES = 64,
  parameter int IW         = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire arfp_pkg::cmd_t q_head,
  output logic                q_pop,
  output logic [IW-1:0]       st_raddr,
  input  wire logic [15:0]    st_rdata,
  output logic                burst_done,
  output logic                out_valid,
  input  wire logic           out_ready,
  output arfp_pkg::result_t   out_data
);

  arfp_pkg::back_state_t state_r, state_nxt;
  logic [arfp_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic [arfp_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       ov_r, ov_nxt;
  arfp_pkg::result_t          od_r, od_nxt;
  logic                       slot_free;
  logic                       is_last;

  assign slot_free = !ov_r || out_ready;
  assign is_last   = ((idx_r + arfp_pkg::CNT_W'(1)) == cnt_r);
  assign st_raddr  = idx_r[IW-1:0];
  assign out_valid = ov_r;
  assign out_data  = od_r;

  // Sequencer: single status results, or read-then-send per reading
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    ov_nxt     = ov_r && !out_ready;
    od_nxt     = od_r;
    q_pop      = 1'b0;
    burst_done = 1'b0;
    unique case (state_r)
      arfp_pkg::B_IDLE: begin
        if (!q_empty) begin
          if (q_head.burst) begin
            q_pop     = 1'b1;
            idx_nxt   = '0;
            cnt_nxt   = q_head.count;
            state_nxt = arfp_pkg::B_READ;
          end else if (slot_free) begin
            q_pop  = 1'b1;
            ov_nxt = 1'b1;
            od_nxt = '{status: q_head.status, has_value: 1'b0, value_index: '0,
                       reading: '0, last: 1'b1};
          end
        end
      end
      arfp_pkg::B_READ: begin
        state_nxt = arfp_pkg::B_SEND;
      end
      arfp_pkg::B_SEND: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          od_nxt = '{status: arfp_pkg::ST_OK, has_value: 1'b1, value_index: idx_r[5:0],
                     reading: st_rdata, last: is_last};
          if (is_last) begin
            burst_done = 1'b1;
            state_nxt  = arfp_pkg::B_IDLE;
          end else begin
            idx_nxt   = idx_r + arfp_pkg::CNT_W'(1);
            state_nxt = arfp_pkg::B_READ;
          end
        end
      end
      default: begin
        state_nxt = arfp_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arfp_pkg::B_IDLE;
      idx_r   <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    od_r <= od_nxt;
  end

endmodule
`default_nettype wire

// ===== src/ascii_response_frame_parser_core.sv =====
// A status result goes through the command queue and then the output register once its input is accepted.
// Burst readings follow a reply's last CR, each one read from the value store, then sent.
// Throughput: one input per cycle while the queue has room; bytes wait while readings are sent.
// A two-entry command queue sits between the parsing front and the result back end.
// Reset (rst_n low, synchronous): frame state, timeout count and queue cleared,
// registers to defaults; the value store is not cleared.
`default_nettype none
module ascii_response_frame_parser_core #(
  parameter int MAX_VALUES    = 64,
  parameter int TIMEOUT_LIMIT = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire arfp_pkg::item_t               in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output arfp_pkg::result_t                  out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [arfp_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int IW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;

  logic [7:0] unit_id_r;
  logic       variant_r;
  logic [6:0] exp_cnt_r;
  logic       cfg_wr;

  logic           q_push, q_pop, q_empty, q_full;
  arfp_pkg::cmd_t q_cmd, q_head;
  logic           burst_done;
  logic           st_we;
  logic [IW-1:0]  st_waddr, st_raddr;
  logic [15:0]    st_wdata, st_rdata;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_id_r <= arfp_pkg::UNIT_ID_RST;
      variant_r <= 1'b0;
      exp_cnt_r <= arfp_pkg::EXP_COUNT_RST;
    end else if (cfg_wr) begin
      if (paddr[3:2] == arfp_pkg::REG_UNIT_ID) begin
        unit_id_r <= pwdata[7:0];
      end
      if (paddr[3:2] == arfp_pkg::REG_VARIANT) begin
        variant_r <= pwdata[0];
      end
      if (paddr[3:2] == arfp_pkg::REG_EXP_COUNT) begin
        exp_cnt_r <= pwdata[6:0];
      end
    end
  end

  // Register read-back
  always_comb begin
    prdata = '0;
    if (paddr[3:2] == arfp_pkg::REG_UNIT_ID) begin
      prdata = {24'd0, unit_id_r};
    end else if (paddr[3:2] == arfp_pkg::REG_VARIANT) begin
      prdata = {31'd0, variant_r};
    end else if (paddr[3:2] == arfp_pkg::REG_EXP_COUNT) begin
      prdata = {25'd0, exp_cnt_r};
    end
  end

  arfp_front #(
    .MAX_VALUES    (MAX_VALUES),
    .TIMEOUT_LIMIT (TIMEOUT_LIMIT),
    .IW            (IW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .unit_id        (unit_id_r),
    .plc_variant    (variant_r),
    .expected_count (exp_cnt_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_cmd),
    .burst_done     (burst_done),
    .st_we          (st_we),
    .st_waddr       (st_waddr),
    .st_wdata       (st_wdata)
  );

  arfp_cmd_fifo u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Value store
  arfp_ram #(
    .WIDTH (16),
    .DEPTH (MAX_VALUES),
    .AW    (IW)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  arfp_back #(
    .MAX_VALUES (MAX_VALUES),
    .IW         (IW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .st_raddr   (st_raddr),
    .st_rdata   (st_rdata),
    .burst_done (burst_done),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire
